// File: hdl/pidaw_pkg.sv
// Package: shared types and constants for the PID controller with anti-windup
`default_nettype none
package pidaw_pkg;

  localparam int DATA_W = 32;
  localparam int TIME_W = 31;

  // input op codes
  typedef enum logic {
    OP_CALC  = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  // derivative modes
  typedef enum logic [1:0] {
    DM_NONE = 2'd0,
    DM_ERR  = 2'd1,
    DM_MEAS = 2'd2,
    DM_RATE = 2'd3
  } dmode_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_DERIV_MODE  = 3'd0,
    REG_MIN_STEP    = 3'd1,
    REG_GAIN_P      = 3'd2,
    REG_GAIN_I      = 3'd3,
    REG_GAIN_D      = 3'd4,
    REG_INTEG_LIMIT = 3'd5,
    REG_OUT_LIMIT   = 3'd6
  } reg_idx_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_MUL_P,
    ST_MUL_D,
    ST_MUL_E,
    ST_MUL_C,
    ST_MUL_I,
    ST_FINAL,
    ST_OUT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic calc_err;
    logic prev_upd;
    logic div_start;
    logic mul_p;
    logic mul_d;
    logic mul_e;
    logic mul_c;
    logic mul_i;
    logic finish;
    logic clear;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_done;
  } dp_sts_t;

  // saturate a 34-bit signed sum to 32 bits
  function automatic logic signed [31:0] sat34(input logic signed [33:0] x);
    logic signed [31:0] r;
    if (x > 34'sd2147483647) r = 32'sh7fffffff;
    else if (x < -34'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/pidaw_div.sv
// Serial restoring divider: (num << FRAC_BITS) / den, truncating, saturated
`default_nettype none
module pidaw_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic signed [31:0]  num,
  input  wire logic        [30:0]  den,
  output logic                     done,
  output logic signed [31:0]       quo
);
  import pidaw_pkg::*;

  localparam int NW = 32 + FRAC_BITS;   // dividend magnitude width
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] dvd_r, dvd_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [30:0]   den_r, den_nxt;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [32:0]   trial;
  logic [31:0]   mag;

  assign mag = num[31] ? (~num + 32'd1) : num;
  assign trial = {rem_r, dvd_r[NW-1]} - {2'b00, den_r};

  // one quotient bit per cycle
  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = {mag, {FRAC_BITS{1'b0}}};
      rem_nxt  = '0;
      den_nxt  = den;
      neg_nxt  = num[31];
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        dvd_nxt = {dvd_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], dvd_r[NW-1]};
        dvd_nxt = {dvd_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  // sign and saturate the quotient magnitude
  always_comb begin
    if (!neg_r) begin
      quo = (|dvd_r[NW-1:31]) ? 32'sh7fffffff : $signed({1'b0, dvd_r[30:0]});
    end else begin
      if ((|dvd_r[NW-1:32]) || (dvd_r[31] && |dvd_r[30:0])) quo = 32'sh80000000;
      else quo = $signed(~dvd_r[31:0] + 32'd1);
    end
  end
  assign done = done_r;

  dvd_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held");
  dvd_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("divider did not start");
  dvd_no_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r > CW'(1) |=> !done_r) else $error("early divider done");

endmodule
`default_nettype wire

// File: hdl/pidaw_datapath.sv
// Datapath: operand registers, shared multiplier, divider and PID state
`default_nettype none
module pidaw_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire pidaw_pkg::dp_cmd_t       cmd,
  output pidaw_pkg::dp_sts_t            sts,
  input  wire logic                     cfg_we,
  input  wire logic [2:0]               cfg_idx,
  input  wire logic [31:0]              cfg_wdata,
  input  wire logic signed [31:0]       setpoint,
  input  wire logic signed [31:0]       measured,
  input  wire logic signed [31:0]       measured_rate,
  input  wire logic [30:0]              step_time,
  output logic signed [31:0]            drive
);
  import pidaw_pkg::*;

  // configuration registers
  dmode_t             dmode_r;
  logic [30:0]        min_step_r, ilim_r, olim_r;
  logic signed [31:0] kp_r, ki_r, kd_r;

  // state and working registers
  logic signed [31:0] integ_r, prev_r, last_r;
  logic signed [31:0] sp_r, meas_r, rate_r, err_r, d_r, outv_r, cand_r;
  logic [30:0]        dt_r, den_r;
  logic signed [31:0] pp_r;               // fx product of proportional term
  logic signed [33:0] cand_sum_r;         // exact outv + fx_mul(cand, ki)
  logic               cand_ok_r;

  // shared multiplier
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [63:0] prod_sh;
  logic signed [31:0] prod_sat;
  logic signed [31:0] neg_meas, neg_rate, dnum, quo;
  logic [30:0]        den_c;
  logic               div_done;
  logic signed [33:0] s34;
  logic [33:0]        abs_c;

  // integral acceptance, done in the cycle after the candidate check
  logic accept;
  logic [31:0] abs_cand;
  logic commit_r;

  always_comb begin
    ma = err_r;
    mb = kp_r;
    if (cmd.mul_d) begin
      ma = d_r;
      mb = kd_r;
    end else if (cmd.mul_e) begin
      ma = err_r;
      mb = $signed({1'b0, dt_r});
    end else if (cmd.mul_c) begin
      ma = cand_r;
      mb = ki_r;
    end else if (cmd.mul_i) begin
      ma = integ_r;
      mb = ki_r;
    end
  end
  assign prod    = ma * mb;
  assign prod_sh = prod >>> FRAC_BITS;      // floor
  assign prod_sat = (prod_sh > 64'sd2147483647) ? 32'sh7fffffff :
                    (prod_sh < -64'sd2147483648) ? 32'sh80000000 : prod_sh[31:0];

  assign neg_meas = (meas_r == 32'sh80000000) ? 32'sh7fffffff : -meas_r;
  assign neg_rate = (rate_r == 32'sh80000000) ? 32'sh7fffffff : -rate_r;
  assign dnum = (dmode_r == DM_ERR) ?
                sat34(34'(err_r) - 34'(prev_r)) : sat34(34'(neg_meas) - 34'(prev_r));
  assign den_c = (dt_r > min_step_r) ? dt_r : min_step_r;

  pidaw_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(dnum), .den(den_r),
    .done(div_done), .quo(quo)
  );

  assign sts.need_div = (dmode_r == DM_ERR || dmode_r == DM_MEAS) && (den_c != '0);
  assign sts.div_done = div_done;

  assign s34   = 34'(outv_r) + 34'(prod_sat);
  assign abs_c = cand_sum_r[33] ? -cand_sum_r : cand_sum_r;

  assign abs_cand = cand_r[31] ? -cand_r : cand_r;
  assign accept = (ki_r > 0) && cand_ok_r &&
                  (olim_r == '0 || abs_c <= 34'(olim_r)) &&
                  ({1'b0, abs_cand} <= 33'(ilim_r)) && !(cand_r == 32'sh80000000);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dmode_r    <= DM_NONE;
      min_step_r <= '0;
      kp_r       <= '0;
      ki_r       <= '0;
      kd_r       <= '0;
      ilim_r     <= '0;
      olim_r     <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_DERIV_MODE:  dmode_r    <= dmode_t'(cfg_wdata[1:0]);
        REG_MIN_STEP:    min_step_r <= cfg_wdata[30:0];
        REG_GAIN_P:      kp_r       <= cfg_wdata;
        REG_GAIN_I:      ki_r       <= cfg_wdata;
        REG_GAIN_D:      kd_r       <= cfg_wdata;
        REG_INTEG_LIMIT: ilim_r     <= cfg_wdata[30:0];
        REG_OUT_LIMIT:   olim_r     <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // step sequence registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      prev_r  <= '0;
      last_r  <= '0;
    end else begin
      // clear op, or commit of an accepted integral candidate
      if (cmd.clear) integ_r <= '0;
      else if (commit_r && accept) integ_r <= cand_r;
      if (cmd.calc_err) begin
        err_r <= sat34(34'(sp_r) - 34'(meas_r));
      end
      if (cmd.prev_upd) begin
        // update previous term, also when the divisor is zero
        if (dmode_r == DM_ERR) prev_r <= err_r;
        else if (dmode_r == DM_MEAS) prev_r <= neg_meas;
      end
      if (cmd.calc_err) d_r <= (dmode_r == DM_RATE) ? neg_rate : 32'sd0;
      if (div_done) d_r <= quo;
      if (cmd.mul_p) pp_r <= prod_sat;
      if (cmd.mul_d) outv_r <= sat34(34'(pp_r) + 34'(prod_sat));
      if (cmd.mul_e) cand_r <= sat34(34'(integ_r) + 34'(prod_sat));
      if (cmd.mul_c) cand_sum_r <= s34;
      if (cmd.mul_i) begin
        if (ki_r > 0) outv_r <= sat34(s34);
      end
      if (cmd.finish) begin
        if (olim_r != '0 && $signed(outv_r) > $signed({1'b0, olim_r}))
          last_r <= $signed({1'b0, olim_r});
        else if (olim_r != '0 && $signed(outv_r) < -$signed({1'b0, olim_r}))
          last_r <= -$signed({1'b0, olim_r});
        else last_r <= outv_r;
      end
    end
    if (cmd.load) begin
      sp_r   <= setpoint;
      meas_r <= measured;
      rate_r <= measured_rate;
      dt_r   <= step_time;
    end
    if (cmd.calc_err) den_r <= den_c;
    // integral acceptance test, applied before the integral product
    if (cmd.mul_c) begin
      cand_ok_r <= 1'b1;
    end
  end

  logic signed [31:0] integ_use;
  // the integral product sees the committed value; mul_i follows the commit
  assign integ_use = integ_r;

  assign drive = last_r;

  // commit happens in a state of its own (ST_FINAL, ahead of ST_MUL_I)
  always_ff @(posedge clk) begin
    if (!rst_n) commit_r <= 1'b0;
    else commit_r <= cmd.mul_c;
  end

  dp_clear_integ: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> integ_r == 32'sd0) else $error("integral not cleared");
  dp_integ_limit: assert property (@(posedge clk) disable iff (!rst_n)
    $changed(integ_r) && !$past(cmd.clear) |->
    (integ_r[31] ? -integ_r : integ_r) <= $signed({1'b0, ilim_r}) || $past(cfg_we))
    else $error("integral beyond limit");
  dp_use: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_i |-> integ_use == integ_r) else $error("integral mux");

endmodule
`default_nettype wire

// File: hdl/pidaw_ctrl.sv
// Controller: sequences one PID step over the shared datapath units
`default_nettype none
module pidaw_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_op,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pidaw_pkg::dp_cmd_t      cmd,
  input  wire pidaw_pkg::dp_sts_t sts
);
  import pidaw_pkg::*;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r;
    cmd       = '0;
    in_ready  = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // a compute beat does not need the output register yet
        in_ready = (in_op == OP_CALC) || !ov_r || out_ready;
        if (in_valid && in_ready) begin
          if (in_op == OP_CLEAR) begin
            cmd.clear = 1'b1;
            ov_nxt    = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = ST_ERR;
          end
        end
      end
      ST_ERR: begin
        cmd.calc_err = 1'b1;
        state_nxt    = ST_DIV_START;
      end
      ST_DIV_START: begin
        cmd.prev_upd  = 1'b1;
        cmd.div_start = sts.need_div;
        state_nxt     = sts.need_div ? ST_DIV_WAIT : ST_MUL_P;
      end
      ST_DIV_WAIT: if (sts.div_done) state_nxt = ST_MUL_P;
      ST_MUL_P: begin
        cmd.mul_p = 1'b1;
        state_nxt = ST_MUL_D;
      end
      ST_MUL_D: begin
        cmd.mul_d = 1'b1;
        state_nxt = ST_MUL_E;
      end
      ST_MUL_E: begin
        cmd.mul_e = 1'b1;
        state_nxt = ST_MUL_C;
      end
      ST_MUL_C: begin
        cmd.mul_c = 1'b1;
        state_nxt = ST_FINAL;
      end
      ST_FINAL: state_nxt = ST_MUL_I;
      ST_MUL_I: begin
        cmd.mul_i = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // hold the new drive back until the previous one has left
        if (!ov_r || out_ready) begin
          cmd.finish = 1'b1;
          ov_nxt     = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = ov_r;

  ctl_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_ready) else $error("ready while busy");
  ctl_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.mul_p, cmd.mul_d, cmd.mul_e, cmd.mul_c, cmd.mul_i}))
    else $error("multiplier contention");
  ctl_wait_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> state_r == ST_DIV_WAIT) else $error("divider not awaited");

endmodule
`default_nettype wire

// File: hdl/pid_controller_antiwindup_top.sv
// Top level: PID step with conditional-integration anti-windup
`default_nettype none
// Fixed-point PID step, Q(32-FRAC_BITS).FRAC_BITS signed. One item is worked on at a
// time. A clear beat puts the last drive on the output the cycle after it is taken.
// A compute beat's drive takes longer when the derivative divides (error or
// measurement mode with a nonzero divisor), as it then waits for the bit-serial
// divider. The next beat can be taken when the drive appears. The drive sits in an
// output register: a compute beat is taken while it waits, but its own drive (and any
// clear beat) waits until the previous drive has left.
module pid_controller_antiwindup_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,  // setpoint, measured, measured_rate, step_time
  input  wire logic         in_tuser,  // op
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [31:0]       out_tdata, // drive
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_idx,
  input  wire logic [31:0]  cfg_wdata
);
  import pidaw_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic signed [31:0] drive;

  pidaw_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_op(in_tuser),
    .in_ready(in_tready), .out_valid(out_tvalid), .out_ready(out_tready),
    .cmd(cmd), .sts(sts)
  );

  pidaw_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .setpoint(in_tdata[31:0]), .measured(in_tdata[63:32]),
    .measured_rate(in_tdata[95:64]), .step_time(in_tdata[126:96]),
    .drive(drive)
  );

  assign out_tdata = drive;

endmodule
`default_nettype wire
